// ----- rtl/core/sid_pkg.sv -----
// shared constants and types of the signed integer divider
`default_nettype none
package sid_pkg;

   localparam int unsigned DATA_WIDTH_DEFAULT = 32;

   // per-transaction flags that travel down the pipeline beside the data
   typedef struct packed {
      logic neg;   // quotient takes a negative sign
      logic dbz;   // divisor was zero
   } sid_ctrl_type;

   // rsp_tuser bit positions
   localparam int unsigned TUSER_SATURATED      = 0;
   localparam int unsigned TUSER_DIVIDE_BY_ZERO = 1;
   localparam int unsigned TUSER_WIDTH          = 2;

endpackage
`default_nettype wire

// ----- rtl/core/signed_int_divider_top.sv -----
// Signed integer divider, quotient truncated toward zero. One transaction is
// accepted per clock cycle while the pipeline is not stalled. An input stage
// takes the operand magnitudes, one restoring subtract stage per quotient bit
// follows, and an output stage fixes the sign and registers the result. When
// the result is not taken the whole pipeline holds and req_tready drops in the
// same cycle. The minimum dividend over minus one returns the maximum positive
// value with saturated set; a zero divisor returns quotient 0 with divide_by_zero
// set.
`default_nettype none
module signed_int_divider_top #(
   parameter int unsigned DATA_WIDTH = sid_pkg::DATA_WIDTH_DEFAULT,
   localparam int unsigned REQ_TDATA_WIDTH = ((2 * DATA_WIDTH + 7) / 8) * 8,
   localparam int unsigned RSP_TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // dividend, divisor, zero fill
   input  wire logic [REQ_TDATA_WIDTH-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // quotient, zero fill
   output logic [RSP_TDATA_WIDTH-1:0]         rsp_tdata,
   // saturated, divide_by_zero
   output logic [sid_pkg::TUSER_WIDTH-1:0]    rsp_tuser
);
   import sid_pkg::*;

   logic advance;

   logic                  valid_s [0:DATA_WIDTH];
   sid_ctrl_type          ctrl_s  [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] rem_s   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] acc_s   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] dmag_s  [0:DATA_WIDTH];

   logic [DATA_WIDTH-1:0] quotient;
   logic                  saturated;
   logic                  divide_by_zero;

   // the pipeline moves as one whenever the result register is free or drained
   assign advance    = ~rsp_tvalid | rsp_tready;
   assign req_tready = advance;

   sid_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .dividend  (req_tdata[DATA_WIDTH-1:0]),
      .divisor   (req_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
      .out_valid (valid_s[0]),
      .out_ctrl  (ctrl_s[0]),
      .out_acc   (acc_s[0]),
      .out_dmag  (dmag_s[0])
   );

   assign rem_s[0] = '0;

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_stage
      sid_stage #(.DATA_WIDTH(DATA_WIDTH)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (valid_s[i]),
         .in_ctrl   (ctrl_s[i]),
         .in_rem    (rem_s[i]),
         .in_acc    (acc_s[i]),
         .in_dmag   (dmag_s[i]),
         .out_valid (valid_s[i+1]),
         .out_ctrl  (ctrl_s[i+1]),
         .out_rem   (rem_s[i+1]),
         .out_acc   (acc_s[i+1]),
         .out_dmag  (dmag_s[i+1])
      );
   end

   sid_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .in_valid           (valid_s[DATA_WIDTH]),
      .in_ctrl            (ctrl_s[DATA_WIDTH]),
      .in_quot            (acc_s[DATA_WIDTH]),
      .out_valid          (rsp_tvalid),
      .out_quotient       (quotient),
      .out_saturated      (saturated),
      .out_divide_by_zero (divide_by_zero)
   );

   assign rsp_tdata = RSP_TDATA_WIDTH'(quotient);

   always_comb begin
      rsp_tuser                       = '0;
      rsp_tuser[TUSER_SATURATED]      = saturated;
      rsp_tuser[TUSER_DIVIDE_BY_ZERO] = divide_by_zero;
   end

   // final remainders and divisor copies are only needed along the way
   logic unused_tail;
   assign unused_tail = ^{rem_s[DATA_WIDTH], dmag_s[DATA_WIDTH]};

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(saturated && divide_by_zero))
      else $error("saturated and divide_by_zero both set");

   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && divide_by_zero) |-> (quotient == '0))
      else $error("divide by zero with nonzero quotient");

   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && saturated) |-> (quotient == {1'b0, {(DATA_WIDTH-1){1'b1}}}))
      else $error("saturated result is not the maximum value");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_s[0] && !advance) |=> valid_s[0])
      else $error("pipeline entry lost during a stall");

endmodule
`default_nettype wire

// ----- rtl/core/sid_prep.sv -----
// input stage: operand magnitudes, sign and divide-by-zero detection
`default_nettype none
module sid_prep #(
   parameter int unsigned DATA_WIDTH = sid_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    in_valid,
   input  wire logic [DATA_WIDTH-1:0]   dividend,
   input  wire logic [DATA_WIDTH-1:0]   divisor,
   output logic                         out_valid,
   output sid_pkg::sid_ctrl_type        out_ctrl,
   output logic [DATA_WIDTH-1:0]        out_acc,
   output logic [DATA_WIDTH-1:0]        out_dmag
);
   import sid_pkg::*;

   logic                  valid_ff;
   sid_ctrl_type          ctrl_ff, ctrl_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] dmag_ff, dmag_in;

   always_comb begin
      // the minimum value maps onto its unsigned magnitude
      acc_in       = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
      dmag_in      = divisor[DATA_WIDTH-1]  ? (~divisor + 1'b1)  : divisor;
      ctrl_in.neg  = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
      ctrl_in.dbz  = (divisor == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctrl_ff <= ctrl_in;
         acc_ff  <= acc_in;
         dmag_ff <= dmag_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_acc   = acc_ff;
   assign out_dmag  = dmag_ff;

endmodule
`default_nettype wire

// ----- rtl/core/sid_stage.sv -----
// one restoring shift-and-subtract step with its pipeline register
`default_nettype none
module sid_stage #(
   parameter int unsigned DATA_WIDTH = sid_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    in_valid,
   input  wire sid_pkg::sid_ctrl_type   in_ctrl,
   input  wire logic [DATA_WIDTH-1:0]   in_rem,
   input  wire logic [DATA_WIDTH-1:0]   in_acc,
   input  wire logic [DATA_WIDTH-1:0]   in_dmag,
   output logic                         out_valid,
   output sid_pkg::sid_ctrl_type        out_ctrl,
   output logic [DATA_WIDTH-1:0]        out_rem,
   output logic [DATA_WIDTH-1:0]        out_acc,
   output logic [DATA_WIDTH-1:0]        out_dmag
);
   import sid_pkg::*;

   logic                  valid_ff;
   sid_ctrl_type          ctrl_ff;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] dmag_ff;
   logic [DATA_WIDTH-1:0] rem_shift;
   logic [DATA_WIDTH:0]   diff;
   logic                  take;

   // acc holds the remaining dividend bits high and the quotient bits found so far low
   always_comb begin
      rem_shift = {in_rem[DATA_WIDTH-2:0], in_acc[DATA_WIDTH-1]};
      diff      = {1'b0, rem_shift} - {1'b0, in_dmag};
      take      = ~diff[DATA_WIDTH];
      rem_in    = take ? diff[DATA_WIDTH-1:0] : rem_shift;
      acc_in    = {in_acc[DATA_WIDTH-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctrl_ff <= in_ctrl;
         rem_ff  <= rem_in;
         acc_ff  <= acc_in;
         dmag_ff <= in_dmag;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_rem   = rem_ff;
   assign out_acc   = acc_ff;
   assign out_dmag  = dmag_ff;

endmodule
`default_nettype wire

// ----- rtl/core/sid_post.sv -----
// output stage: sign fix-up, zero result on divide by zero, clamping and the result register
`default_nettype none
module sid_post #(
   parameter int unsigned DATA_WIDTH = sid_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    in_valid,
   input  wire sid_pkg::sid_ctrl_type   in_ctrl,
   input  wire logic [DATA_WIDTH-1:0]   in_quot,
   output logic                         out_valid,
   output logic [DATA_WIDTH-1:0]        out_quotient,
   output logic                         out_saturated,
   output logic                         out_divide_by_zero
);
   import sid_pkg::*;

   localparam logic [DATA_WIDTH-1:0] QUOT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] quot_ff, quot_in;
   logic                  sat_ff, sat_in;
   logic                  dbz_ff;

   always_comb begin
      sat_in  = 1'b0;
      quot_in = in_quot;
      priority if (in_ctrl.dbz) begin
         quot_in = '0;
      end else if (in_ctrl.neg) begin
         quot_in = ~in_quot + 1'b1;
      end else if (in_quot[DATA_WIDTH-1]) begin
         // only the minimum over minus one gets here
         quot_in = QUOT_MAX;
         sat_in  = 1'b1;
      end else begin
         quot_in = in_quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quot_ff <= quot_in;
         sat_ff  <= sat_in;
         dbz_ff  <= in_ctrl.dbz;
      end
   end

   assign out_valid          = valid_ff;
   assign out_quotient       = quot_ff;
   assign out_saturated      = sat_ff;
   assign out_divide_by_zero = dbz_ff;

endmodule
`default_nettype wire

// ----- tb/sv/sid_quotient_checker.sv -----
// checker for the signed integer divider: predicts each quotient and compares results
`default_nettype none
module sid_quotient_checker #(
   parameter int unsigned DATA_WIDTH = sid_pkg::DATA_WIDTH_DEFAULT,
   localparam int unsigned REQ_TDATA_WIDTH = ((2 * DATA_WIDTH + 7) / 8) * 8,
   localparam int unsigned RSP_TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   input  wire logic                          req_tready,
   // dividend, divisor, zero fill
   input  wire logic [REQ_TDATA_WIDTH-1:0]    req_tdata,
   input  wire logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   // quotient, zero fill
   input  wire logic [RSP_TDATA_WIDTH-1:0]    rsp_tdata,
   // saturated, divide_by_zero
   input  wire logic [sid_pkg::TUSER_WIDTH-1:0] rsp_tuser,
   output int                                 mismatch_count,
   output int                                 quotients_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] quotient;
      logic                  saturated;
      logic                  divide_by_zero;
   } quotient_result_type;

   quotient_result_type expected_quotients[$];
   int                  errors_seen = 0;

   // truncating division one bit wider than the operands, so the minimum over
   // minus one stays representable and can be clamped afterwards
   function automatic quotient_result_type divide_truncating(
      input logic [DATA_WIDTH-1:0] dividend,
      input logic [DATA_WIDTH-1:0] divisor
   );
      logic signed [DATA_WIDTH:0] wide_dividend;
      logic signed [DATA_WIDTH:0] wide_divisor;
      logic signed [DATA_WIDTH:0] wide_quotient;
      quotient_result_type        res;
      res = '0;
      if (divisor == '0) begin
         res.divide_by_zero = 1'b1;
         return res;
      end
      wide_dividend = {dividend[DATA_WIDTH-1], dividend};
      wide_divisor  = {divisor[DATA_WIDTH-1], divisor};
      wide_quotient = wide_dividend / wide_divisor;
      if (!wide_quotient[DATA_WIDTH] && wide_quotient[DATA_WIDTH-1]) begin
         res.quotient  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
         res.saturated = 1'b1;
      end else begin
         res.quotient = wide_quotient[DATA_WIDTH-1:0];
      end
      return res;
   endfunction

   always @(posedge clock) begin
      quotient_result_type want;
      quotient_result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_quotients.push_back(divide_truncating(
               req_tdata[DATA_WIDTH-1:0], req_tdata[2*DATA_WIDTH-1:DATA_WIDTH]));
         if (rsp_tvalid && rsp_tready) begin
            got.quotient       = rsp_tdata[DATA_WIDTH-1:0];
            got.saturated      = rsp_tuser[sid_pkg::TUSER_SATURATED];
            got.divide_by_zero = rsp_tuser[sid_pkg::TUSER_DIVIDE_BY_ZERO];
            if (expected_quotients.size() == 0) begin
               $error("unexpected result transaction: quotient %0d", $signed(got.quotient));
               errors_seen++;
            end else begin
               want = expected_quotients.pop_front();
               if (got.quotient !== want.quotient) begin
                  $error("quotient: expected %0d, got %0d",
                         $signed(want.quotient), $signed(got.quotient));
                  errors_seen++;
               end
               if (got.saturated !== want.saturated) begin
                  $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
                  errors_seen++;
               end
               if (got.divide_by_zero !== want.divide_by_zero) begin
                  $error("divide_by_zero: expected %0b, got %0b",
                         want.divide_by_zero, got.divide_by_zero);
                  errors_seen++;
               end
            end
         end
      end
      quotients_pending <= expected_quotients.size();
      mismatch_count    <= errors_seen;
   end

endmodule
`default_nettype wire

// ----- tb/sv/tb_signed_int_divider_top.sv -----
// top of the signed integer divider testbench: clock, reset, operand stimulus and verdict
`default_nettype none
module tb_signed_int_divider_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DATA_WIDTH      = 32;
   localparam int unsigned REQ_TDATA_WIDTH = ((2 * DATA_WIDTH + 7) / 8) * 8;
   localparam int unsigned RSP_TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int unsigned RANDOM_ITEMS    = 1030;
   localparam logic [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] VAL_NEG_ONE = '1;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [REQ_TDATA_WIDTH-1:0]       req_tdata;   // dividend, divisor, zero fill
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [RSP_TDATA_WIDTH-1:0]       rsp_tdata;   // quotient, zero fill
   logic [sid_pkg::TUSER_WIDTH-1:0]  rsp_tuser;   // saturated, divide_by_zero
   int                               mismatch_count;
   int                               quotients_pending;
   bit                               no_idle = 1'b0;

   signed_int_divider_top #(.DATA_WIDTH(DATA_WIDTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   sid_quotient_checker #(.DATA_WIDTH(DATA_WIDTH)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .mismatch_count    (mismatch_count),
      .quotients_pending (quotients_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // result side back-pressure
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = no_idle || ($urandom_range(0, 99) >= 11);
      end
   end

   task automatic send_operands(input logic [DATA_WIDTH-1:0] dividend,
                                input logic [DATA_WIDTH-1:0] divisor);
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < 11) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = REQ_TDATA_WIDTH'({divisor, dividend});
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [DATA_WIDTH-1:0] pick_special(input int unsigned sel);
      case (sel % 6)
         0: return '0;
         1: return DATA_WIDTH'(1);
         2: return VAL_NEG_ONE;
         3: return VAL_MIN;
         4: return VAL_MAX;
         default: return DATA_WIDTH'($urandom());
      endcase
   endfunction

   initial begin
      logic [DATA_WIDTH-1:0] dividend;
      logic [DATA_WIDTH-1:0] divisor;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      reset      = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero divisor, minimum over minus one, minimum divisor and sign corners
      send_operands('0, '0);
      send_operands(DATA_WIDTH'(1), '0);
      send_operands(VAL_MIN, '0);
      send_operands(VAL_MAX, '0);
      send_operands(VAL_MIN, VAL_NEG_ONE);
      send_operands(VAL_MIN, VAL_MIN);
      send_operands(DATA_WIDTH'(5), VAL_MIN);
      send_operands(VAL_NEG_ONE, VAL_MIN);
      send_operands(VAL_MAX, VAL_MIN);
      send_operands(VAL_MIN, DATA_WIDTH'(1));
      send_operands(VAL_MIN, DATA_WIDTH'(2));
      send_operands(VAL_MAX, VAL_NEG_ONE);
      send_operands(VAL_MAX, VAL_MAX);
      send_operands(VAL_MAX, DATA_WIDTH'(1));
      send_operands(DATA_WIDTH'(-7), DATA_WIDTH'(2));
      send_operands(DATA_WIDTH'(7), DATA_WIDTH'(-2));
      send_operands(DATA_WIDTH'(-7), DATA_WIDTH'(-2));
      send_operands(DATA_WIDTH'(7), DATA_WIDTH'(2));
      send_operands('0, DATA_WIDTH'(5));
      send_operands(DATA_WIDTH'(3), DATA_WIDTH'(7));
      send_operands(VAL_NEG_ONE, DATA_WIDTH'(1));

      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         // a stretch in the middle with neither side holding off
         no_idle  = (n >= 300 && n < 500);
         dividend = DATA_WIDTH'($urandom());
         divisor  = DATA_WIDTH'($urandom());
         case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            4, 5: divisor = DATA_WIDTH'(int'($urandom_range(0, 200)) - 100);
            6: divisor = pick_special($urandom());
            7: dividend = pick_special($urandom());
            default: begin
               // spread divisor magnitudes so quotients take every length
               divisor = DATA_WIDTH'($urandom()) >> $urandom_range(0, DATA_WIDTH - 1);
               if ($urandom_range(0, 1) == 1)
                  divisor = -divisor;
            end
         endcase
         send_operands(dividend, divisor);
      end
      @(negedge clock);
      req_tvalid = 1'b0;
      no_idle    = 1'b0;

      do @(posedge clock); while (quotients_pending != 0);
      repeat (DATA_WIDTH + 8) @(posedge clock);
      if (mismatch_count == 0 && quotients_pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
`default_nettype wire
